@@ rtl/core/imupc_pkg.sv @@
// Shared types and constants for the IMU packet checksum parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package imupc_pkg;

	localparam logic [7:0] SYNC_RESET   = 8'h55;
	localparam logic [7:0] TYPE_ACCEL   = 8'h51;
	localparam logic [7:0] TYPE_GYRO    = 8'h52;
	localparam logic [7:0] TYPE_ANGLE   = 8'h53;
	localparam logic [7:0] TYPE_MAG     = 8'h54;
	localparam logic [3:0] POS_HUNT     = 4'd0;
	localparam logic [3:0] POS_TYPE     = 4'd1;
	localparam logic [3:0] POS_LAST     = 4'd10;
	localparam int         PAYLOAD_LEN  = 8;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SUM  = 2'd1,
		ST_BAD_TYPE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_ACCEL = 2'd0,
		KIND_GYRO  = 2'd1,
		KIND_ANGLE = 2'd2,
		KIND_MAG   = 2'd3
	} kind_t;

	typedef struct packed {
		status_t            status;
		kind_t              kind;
		logic signed [15:0] word_a;
		logic signed [15:0] word_b;
		logic signed [15:0] word_c;
		logic signed [15:0] word_d;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/imupc_framer.sv @@
// Input stage, packet framing state, checksum and result decode.
// Depends on imupc_pkg; feeds imupc_out_reg.
`default_nettype none

module imupc_framer
	import imupc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic [7:0] cfg_data,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       res_free,
	output logic            res_load,
	output result_t         res
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [7:0] sync_q;
	logic [3:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] type_q;
	logic [7:0] store_q [PAYLOAD_LEN];
	logic       is_last;
	logic       is_hunt;
	logic       consume;
	logic [2:0] store_idx;

	assign is_last   = (pos_q == POS_LAST);
	assign is_hunt   = (pos_q == POS_HUNT) || (pos_q > POS_LAST);
	assign consume   = valid_s1 && (!is_last || res_free);
	assign rx_ready  = !valid_s1 || consume;
	assign res_load  = consume && is_last;
	assign store_idx = 3'(pos_q - 4'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sync_q   <= SYNC_RESET;
		end else begin
			if (rx_ready) begin
				valid_s1 <= rx_valid;
			end
			if (cfg_valid) begin
				sync_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HUNT;
			sum_q  <= '0;
			type_q <= '0;
		end else if (consume) begin
			if (is_hunt) begin
				if (byte_s1 == sync_q) begin
					sum_q <= byte_s1;
					pos_q <= POS_TYPE;
				end else begin
					pos_q <= POS_HUNT;
				end
			end else if (is_last) begin
				sum_q <= '0;
				pos_q <= POS_HUNT;
			end else begin
				if (pos_q == POS_TYPE) begin
					type_q <= byte_s1;
				end
				sum_q <= sum_q + byte_s1;
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume && !is_hunt && !is_last && pos_q != POS_TYPE) begin
			store_q[store_idx] <= byte_s1;
		end
	end

	always_comb begin
		res.status = ST_OK;
		res.kind   = KIND_ACCEL;
		if (sum_q != byte_s1) begin
			res.status = ST_BAD_SUM;
		end else begin
			case (type_q)
				TYPE_ACCEL: res.kind = KIND_ACCEL;
				TYPE_GYRO:  res.kind = KIND_GYRO;
				TYPE_ANGLE: res.kind = KIND_ANGLE;
				TYPE_MAG:   res.kind = KIND_MAG;
				default:    res.status = ST_BAD_TYPE;
			endcase
		end
		res.word_a = {store_q[1], store_q[0]};
		res.word_b = {store_q[3], store_q[2]};
		res.word_c = {store_q[5], store_q[4]};
		res.word_d = {store_q[7], store_q[6]};
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("byte position out of range");

	a_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (pos_q == POS_HUNT) && (sum_q == 8'd0))
		else $error("framer did not return to hunting after a packet");

	a_sync_start: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && is_hunt && byte_s1 == sync_q) |=> pos_q == POS_TYPE)
		else $error("sync byte did not open a packet");

endmodule

`default_nettype wire

@@ rtl/core/imupc_out_reg.sv @@
// Result register holding one finished packet until the sink takes it.
// Depends on imupc_pkg; loaded by imupc_framer.
`default_nettype none

module imupc_out_reg
	import imupc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_load,
	input  wire result_t res,
	output logic         res_free,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      res_q
);

	logic valid_q;

	assign out_valid = valid_q;
	assign res_free  = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> res_free)
		else $error("result loaded over an untaken beat");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> valid_q)
		else $error("loaded result not presented");

endmodule

`default_nettype wire

@@ rtl/core/imu_packet_checksum_parser.sv @@
// Top level of the IMU packet checksum parser.
// Depends on imupc_pkg, imupc_framer and imupc_out_reg.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | sync_value[7:0]
//  rx      | rx_valid/rx_ready    | rx_byte[7:0]
//  out     | out_valid/out_ready  | status, packet_kind, word_a..word_d
//
// One byte per cycle sustained unless a waiting result stalls a checksum byte.
// Latency is set by the input register and the result register.
// arst_n clears framing state, sync_value to 0x55 and both valid flags.
// A waiting result stalls only a checksum byte; other bytes keep flowing.
// cfg_ready is always high.
`default_nettype none

module imu_packet_checksum_parser
	import imupc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         sync_value,
	input  wire logic               rx_valid,
	output logic                    rx_ready,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [1:0]              packet_kind,
	output logic signed [15:0]      word_a,
	output logic signed [15:0]      word_b,
	output logic signed [15:0]      word_c,
	output logic signed [15:0]      word_d
);

	logic    res_load;
	logic    res_free;
	result_t res;
	result_t res_q;

	assign cfg_ready = 1'b1;

	imupc_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (sync_value),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.res_free (res_free),
		.res_load (res_load),
		.res      (res)
	);

	imupc_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_load (res_load),
		.res      (res),
		.res_free (res_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res_q    (res_q)
	);

	assign status      = res_q.status;
	assign packet_kind = res_q.kind;
	assign word_a      = res_q.word_a;
	assign word_b      = res_q.word_b;
	assign word_c      = res_q.word_c;
	assign word_d      = res_q.word_d;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for imu_packet_checksum_parser: framing, checksum and type status.
// Needs imupc_pkg and the parser RTL; an in-bench frame tracker predicts every result.

module testbench;
	import imupc_pkg::*;

	localparam int CYCLE_LIMIT   = 100000;
	localparam int RANDOM_BYTES  = 1900;
	localparam int PHASES        = 6;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 6;

	class imu_frame_tracker;
		logic [7:0] sync_reg;
		logic [3:0] pos;
		logic [7:0] sum;
		logic [7:0] type_byte;
		logic [7:0] payload [8];
		result_t    pending_frames [$];
		int         framed;
		int         checked;
		int         mismatches;
		int         ok_n;
		int         bad_sum_n;
		int         bad_type_n;

		function new();
			sync_reg  = SYNC_RESET;
			pos       = POS_HUNT;
			sum       = '0;
			type_byte = '0;
			foreach (payload[i]) payload[i] = '0;
		endfunction

		function void set_sync(logic [7:0] v);
			sync_reg = v;
		endfunction

		function int pending();
			return pending_frames.size();
		endfunction

		function void note_byte(logic [7:0] b);
			result_t r;
			if (pos == POS_HUNT || pos > POS_LAST) begin
				if (b == sync_reg) begin
					sum = b;
					pos = POS_TYPE;
					framed++;
				end else
					pos = POS_HUNT;
				return;
			end
			framed++;
			if (pos == POS_TYPE) begin
				type_byte = b;
				sum += b;
				pos++;
			end else if (pos < POS_LAST) begin
				payload[3'(pos - 4'd2)] = b;
				sum += b;
				pos++;
			end else begin
				r.status = ST_OK;
				r.kind   = KIND_ACCEL;
				if (sum != b)
					r.status = ST_BAD_SUM;
				else case (type_byte)
					TYPE_ACCEL: r.kind = KIND_ACCEL;
					TYPE_GYRO:  r.kind = KIND_GYRO;
					TYPE_ANGLE: r.kind = KIND_ANGLE;
					TYPE_MAG:   r.kind = KIND_MAG;
					default:    r.status = ST_BAD_TYPE;
				endcase
				r.word_a = {payload[1], payload[0]};
				r.word_b = {payload[3], payload[2]};
				r.word_c = {payload[5], payload[4]};
				r.word_d = {payload[7], payload[6]};
				case (r.status)
					ST_OK:      ok_n++;
					ST_BAD_SUM: bad_sum_n++;
					default:    bad_type_n++;
				endcase
				pending_frames.push_back(r);
				pos = POS_HUNT;
				sum = '0;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			checked++;
			if (pending_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result status=%0d kind=%0d words=%h %h %h %h",
						got.status, got.kind, got.word_a, got.word_b, got.word_c, got.word_d);
				return;
			end
			want = pending_frames.pop_front();
			if (got.status !== want.status || got.kind !== want.kind ||
					got.word_a !== want.word_a || got.word_b !== want.word_b ||
					got.word_c !== want.word_c || got.word_d !== want.word_d) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: result %0d expected status=%0d kind=%0d words=%h %h %h %h",
						checked, want.status, want.kind,
						want.word_a, want.word_b, want.word_c, want.word_d);
					$display("       got      status=%0d kind=%0d words=%h %h %h %h",
						got.status, got.kind, got.word_a, got.word_b, got.word_c, got.word_d);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               cfg_valid  = 1'b0;
	logic               cfg_ready;
	logic [7:0]         sync_value = 8'h00;
	logic               rx_valid   = 1'b0;
	logic               rx_ready;
	logic [7:0]         rx_byte    = 8'h00;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [1:0]         status;
	logic [1:0]         packet_kind;
	logic signed [15:0] word_a;
	logic signed [15:0] word_b;
	logic signed [15:0] word_c;
	logic signed [15:0] word_d;

	imu_frame_tracker tracker = new();
	bit rx_steady    = 1'b0;
	bit out_steady   = 1'b0;
	bit hold_request = 1'b0;
	int cycle_count  = 0;
	int sync_writes  = 0;

	imu_packet_checksum_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.sync_value  (sync_value),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.packet_kind (packet_kind),
		.word_a      (word_a),
		.word_b      (word_b),
		.word_c      (word_c),
		.word_d      (word_d)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ERROR: timeout after %0d cycles, %0d results outstanding",
			cycle_count, tracker.pending());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : result_sink
		int      hold_left;
		result_t got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.status = status_t'(status);
				got.kind   = kind_t'(packet_kind);
				got.word_a = word_a;
				got.word_b = word_b;
				got.word_c = word_c;
				got.word_d = word_d;
				tracker.check_result(got);
			end
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= out_steady || ($urandom_range(99) >= 37);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (!rx_steady)
			while (gap < 20 && $urandom_range(99) < 37) gap++;
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!rx_ready);
		tracker.note_byte(b);
	endtask

	task automatic send_packet(input logic [7:0] head, input logic [7:0] kind_byte,
			input logic [63:0] body, input logic [7:0] sum_offset);
		logic [7:0] sum;
		sum = head + kind_byte + sum_offset;
		send_byte(head);
		send_byte(kind_byte);
		for (int i = 0; i < 8; i++) begin
			sum += body[8*i +: 8];
			send_byte(body[8*i +: 8]);
		end
		send_byte(sum);
	endtask

	// drop valid, let every predicted result drain, then let the pipeline settle
	task automatic wait_results();
		rx_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sync(input logic [7:0] v);
		cfg_valid  <= 1'b1;
		sync_value <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.set_sync(v);
		sync_writes++;
	endtask

	task automatic send_random_unit();
		int          pick;
		int          n;
		logic [7:0]  kind_byte;
		logic [63:0] body;
		logic [7:0]  offset;
		pick = $urandom_range(99);
		if (pick < 72) begin
			kind_byte = ($urandom_range(99) < 85) ? 8'(TYPE_ACCEL + $urandom_range(3))
				: 8'($urandom_range(255));
			case ($urandom_range(9))
				0:       body = '0;
				1:       body = '1;
				2:       body = {4{16'h8000}};
				3:       body = {4{16'h7FFF}};
				default: body = {$urandom, $urandom};
			endcase
			offset = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
			send_packet(tracker.sync_reg, kind_byte, body, offset);
		end else if (pick < 86) begin
			n = $urandom_range(1, 4);
			repeat (n) send_byte(8'($urandom_range(255)));
		end else begin
			send_byte(tracker.sync_reg);
			n = $urandom_range(1, 9);
			repeat (n) send_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin : stimulus
		logic [7:0] phase_syncs [PHASES];
		logic [7:0] partial_sum;
		int         target;
		phase_syncs = '{8'hFF, 8'h00, 8'h00, 8'h00, SYNC_RESET, 8'h00};
		phase_syncs[1] = 8'($urandom_range(255));
		phase_syncs[3] = 8'($urandom_range(255));
		phase_syncs[5] = 8'($urandom_range(255));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise while hunting, then one packet per kind and each failure mode
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hAA);
		send_packet(SYNC_RESET, TYPE_ACCEL, 64'h0, 8'h00);
		send_packet(SYNC_RESET, TYPE_GYRO, {16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'h00);
		send_packet(SYNC_RESET, TYPE_ANGLE, '1, 8'h00);
		send_packet(SYNC_RESET, TYPE_MAG, {$urandom, $urandom}, 8'h00);
		send_packet(SYNC_RESET, TYPE_ACCEL, {$urandom, $urandom}, 8'h01);
		send_packet(SYNC_RESET, 8'h50, {$urandom, $urandom}, 8'h00);
		send_packet(SYNC_RESET, 8'h00, {$urandom, $urandom}, 8'h80);
		// sync bytes inside a rejected packet must not resync
		send_packet(SYNC_RESET, TYPE_ACCEL, {8{SYNC_RESET}}, 8'h05);
		send_packet(SYNC_RESET, TYPE_GYRO, {$urandom, $urandom}, 8'h00);

		// change the sync byte in mid-packet; the open packet keeps its sum
		partial_sum = SYNC_RESET + TYPE_ANGLE;
		send_byte(SYNC_RESET);
		send_byte(TYPE_ANGLE);
		for (int i = 1; i <= 3; i++) begin
			partial_sum += 8'(i * 16);
			send_byte(8'(i * 16));
		end
		wait_results();
		write_sync(8'h00);
		for (int i = 4; i <= 8; i++) begin
			partial_sum += 8'(i * 16);
			send_byte(8'(i * 16));
		end
		send_byte(partial_sum);

		for (int p = 0; p < PHASES; p++) begin
			wait_results();
			write_sync(phase_syncs[p]);
			rx_steady  = (p == 1 || p == 3);
			out_steady = (p == 3);
			if (p == 1)
				hold_request = 1'b1;
			target = tracker.framed + RANDOM_BYTES / PHASES;
			while (tracker.framed < target) send_random_unit();
		end

		wait_results();
		$display("Run covered %0d framed bytes and %0d results: %0d ok, %0d bad checksum,",
			tracker.framed, tracker.checked, tracker.ok_n, tracker.bad_sum_n);
		$display("%0d unknown type; sync byte written %0d times, one %0d-cycle output stall.",
			tracker.bad_type_n, sync_writes, HOLD_CYCLES);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("Simulation PASSED");
		else begin
			$display("ERROR: %0d mismatches, %0d results outstanding",
				tracker.mismatches, tracker.pending());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
